/* design/ptc_pkg.sv */
`timescale 1ns / 1ps

package ptc_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_GROUP_A = 2'd0;
	localparam logic [1:0] CFG_GROUP_B = 2'd1;
	localparam logic [1:0] CFG_GROUP_C = 2'd2;

	// Fixed constants of the compensation formulas.
	localparam logic signed [31:0] FINE_OFFSET = 32'sd128000;
	localparam logic [20:0] PRESSURE_BIAS = 21'd1048576;
	localparam logic signed [63:0] PRESSURE_SCALE = 64'sd3125;
	localparam logic signed [63:0] V1_OFFSET = 64'sh0000_8000_0000_0000;
	localparam logic signed [35:0] ROUND_HALF = 36'sd128;
	localparam logic signed [35:0] TEMP_MAX = 36'sd524287;
	localparam logic signed [35:0] TEMP_MIN = -36'sd524288;

	// One input item.
	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
	} sample_t;

	// One result item.
	typedef struct packed {
		logic signed [19:0] temperature;
		logic [31:0] pressure;
		logic pressure_valid;
	} result_t;

	// Calibration words unpacked from the three configuration registers.
	typedef struct packed {
		logic [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} calib_t;

	// Values that ride alongside the pressure division.
	typedef struct packed {
		logic signed [19:0] temperature;
		logic zero_div;
		logic negate;
	} div_side_t;

endpackage

/* design/ptc_front.sv */
`timescale 1ns / 1ps

module ptc_front import ptc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input calib_t cal,
	input logic in_valid,
	input sample_t in_item,
	output logic out_valid,
	output logic [63:0] out_num,
	output logic [63:0] out_den,
	output div_side_t out_side
);

	// Valid bits for the ten stages.
	logic [10:1] vld_q;

	// Stage 1: temperature difference products.
	logic signed [17:0] ta;
	logic signed [17:0] td;
	logic signed [33:0] ap;
	logic signed [35:0] dd;
	logic signed [33:0] ap_s1;
	logic signed [35:0] dd_s1;
	logic [19:0] adcp_s1;

	assign ta = signed'({1'b0, in_item.raw_temperature[19:3]}) - signed'({1'b0, cal.t1, 1'b0});
	assign td = signed'({2'b0, in_item.raw_temperature[19:4]}) - signed'({2'b0, cal.t1});
	assign ap = ta * cal.t2;
	assign dd = td * td;

	always_ff @(posedge clk) begin
		if (adv) begin
			ap_s1 <= ap;
			dd_s1 <= dd;
			adcp_s1 <= in_item.raw_pressure;
		end
	end

	// Stage 2: second temperature term product.
	logic signed [39:0] bp;
	logic signed [33:0] a_s2;
	logic signed [39:0] bp_s2;
	logic [19:0] adcp_s2;

	assign bp = 40'(dd_s1 >>> 12) * 40'(cal.t3);

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2 <= ap_s1 >>> 11;
			bp_s2 <= bp;
			adcp_s2 <= adcp_s1;
		end
	end

	// Stage 3: fine temperature.
	logic signed [31:0] fine_s3;
	logic [19:0] adcp_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			fine_s3 <= 32'(a_s2) + 32'(bp_s2 >>> 14);
			adcp_s3 <= adcp_s2;
		end
	end

	// Stage 4: temperature in hundredths, saturated, and the pressure offset.
	logic signed [35:0] tw;
	logic signed [35:0] tsh;
	logic signed [19:0] tclamp;
	logic signed [19:0] temp_s4;
	logic signed [31:0] v1_s4;
	logic [19:0] adcp_s4;

	assign tw = 36'(fine_s3) * 36'sd5 + ROUND_HALF;
	assign tsh = tw >>> 8;

	always_comb begin
		if (tsh > TEMP_MAX) begin
			tclamp = 20'(TEMP_MAX);
		end else if (tsh < TEMP_MIN) begin
			tclamp = 20'(TEMP_MIN);
		end else begin
			tclamp = 20'(tsh);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			temp_s4 <= tclamp;
			v1_s4 <= fine_s3 - FINE_OFFSET;
			adcp_s4 <= adcp_s3;
		end
	end

	// Stage 5: square of the offset and linear terms.
	logic signed [63:0] vv_s5;
	logic signed [47:0] v1p5_s5;
	logic signed [47:0] v1p2_s5;
	logic signed [19:0] temp_s5;
	logic [19:0] adcp_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			vv_s5 <= 64'(v1_s4) * 64'(v1_s4);
			v1p5_s5 <= 48'(v1_s4) * 48'(cal.p5);
			v1p2_s5 <= 48'(v1_s4) * 48'(cal.p2);
			temp_s5 <= temp_s4;
			adcp_s5 <= adcp_s4;
		end
	end

	// Stage 6: quadratic terms, wrapping at 64 bits.
	logic signed [63:0] v2a_s6;
	logic signed [63:0] v1a_s6;
	logic signed [47:0] v1p5_s6;
	logic signed [47:0] v1p2_s6;
	logic signed [19:0] temp_s6;
	logic [19:0] adcp_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			v2a_s6 <= vv_s5 * 64'(cal.p6);
			v1a_s6 <= vv_s5 * 64'(cal.p3);
			v1p5_s6 <= v1p5_s5;
			v1p2_s6 <= v1p2_s5;
			temp_s6 <= temp_s5;
			adcp_s6 <= adcp_s5;
		end
	end

	// Stage 7: sums for the numerator offset and the divisor.
	logic signed [63:0] v2_s7;
	logic signed [63:0] v1b_s7;
	logic signed [19:0] temp_s7;
	logic [19:0] adcp_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			v2_s7 <= v2a_s6 + (64'(v1p5_s6) <<< 17) + (64'(cal.p4) <<< 35);
			v1b_s7 <= (v1a_s6 >>> 8) + (64'(v1p2_s6) <<< 12);
			temp_s7 <= temp_s6;
			adcp_s7 <= adcp_s6;
		end
	end

	// Stage 8: divisor scaling product and raw numerator.
	logic [20:0] pp;
	logic signed [63:0] mp_s8;
	logic signed [63:0] n0_s8;
	logic signed [19:0] temp_s8;

	assign pp = PRESSURE_BIAS - {1'b0, adcp_s7};

	always_ff @(posedge clk) begin
		if (adv) begin
			mp_s8 <= (v1b_s7 + V1_OFFSET) * signed'(64'(cal.p1));
			n0_s8 <= signed'({43'b0, pp} << 31) - v2_s7;
			temp_s8 <= temp_s7;
		end
	end

	// Stage 9: final divisor and scaled numerator.
	logic signed [63:0] den_s9;
	logic signed [63:0] num_s9;
	logic signed [19:0] temp_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s9 <= mp_s8 >>> 33;
			num_s9 <= n0_s8 * PRESSURE_SCALE;
			temp_s9 <= temp_s8;
		end
	end

	// Stage 10: magnitudes and quotient sign for the unsigned divider.
	logic [63:0] an_s10;
	logic [63:0] ad_s10;
	div_side_t side_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			an_s10 <= num_s9[63] ? 64'(-num_s9) : 64'(num_s9);
			ad_s10 <= den_s9[63] ? 64'(-den_s9) : 64'(den_s9);
			side_s10.temperature <= temp_s9;
			side_s10.zero_div <= (den_s9 == 64'sd0);
			side_s10.negate <= num_s9[63] ^ den_s9[63];
		end
	end

	// Valid bits advance with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[9:1], in_valid};
		end
	end

	assign out_valid = vld_q[10];
	assign out_num = an_s10;
	assign out_den = ad_s10;
	assign out_side = side_s10;

endmodule

/* design/ptc_div.sv */
`timescale 1ns / 1ps

module ptc_div import ptc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic in_valid,
	input logic [63:0] in_num,
	input logic [63:0] in_den,
	input div_side_t in_side,
	output logic out_valid,
	output logic [63:0] out_quo,
	output div_side_t out_side
);

	// One restoring step per stage; the numerator shifts out as quotient bits shift in.
	logic [63:0] rem_s [0:64];
	logic [63:0] nq_s [0:64];
	logic [63:0] den_s [0:64];
	div_side_t side_s [0:64];
	logic [64:0] vld_s;

	assign rem_s[0] = '0;
	assign nq_s[0] = in_num;
	assign den_s[0] = in_den;
	assign side_s[0] = in_side;
	assign vld_s[0] = in_valid;

	for (genvar i = 0; i < 64; i++) begin : g_step
		logic [64:0] trial;
		logic ge;

		assign trial = {rem_s[i], nq_s[i][63]};
		assign ge = (trial >= {1'b0, den_s[i]});

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i + 1] <= ge ? 64'(trial - {1'b0, den_s[i]}) : trial[63:0];
				nq_s[i + 1] <= {nq_s[i][62:0], ge};
				den_s[i + 1] <= den_s[i];
				side_s[i + 1] <= side_s[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i + 1] <= 1'b0;
			end else if (adv) begin
				vld_s[i + 1] <= vld_s[i];
			end
		end
	end

	assign out_valid = vld_s[64];
	assign out_quo = nq_s[64];
	assign out_side = side_s[64];

endmodule

/* design/ptc_back.sv */
`timescale 1ns / 1ps

module ptc_back import ptc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input calib_t cal,
	input logic in_valid,
	input logic [63:0] in_quo,
	input div_side_t in_side,
	output logic out_valid,
	output result_t out_item
);

	logic [5:1] vld_q;

	// Stage 1: signed quotient.
	logic signed [63:0] q_s1;
	div_side_t side_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s1 <= in_side.negate ? signed'(64'(-in_quo)) : signed'(in_quo);
			side_s1 <= in_side;
		end
	end

	// Stage 2: first factors of the two correction terms.
	logic signed [63:0] q13;
	logic signed [63:0] q_s2;
	logic signed [63:0] q13_s2;
	logic signed [63:0] p9q_s2;
	logic signed [63:0] p8p_s2;
	div_side_t side_s2;

	assign q13 = q_s1 >>> 13;

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s2 <= q_s1;
			q13_s2 <= q13;
			p9q_s2 <= q13 * 64'(cal.p9);
			p8p_s2 <= q_s1 * 64'(cal.p8);
			side_s2 <= side_s1;
		end
	end

	// Stage 3: low 64 bits of the square term from 32-bit partial products.
	logic [63:0] ll_s3;
	logic [31:0] lh_s3;
	logic [31:0] hl_s3;
	logic signed [63:0] q_s3;
	logic signed [63:0] p8p_s3;
	div_side_t side_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			ll_s3 <= 64'(p9q_s2[31:0]) * 64'(q13_s2[31:0]);
			lh_s3 <= 32'(p9q_s2[31:0] * q13_s2[63:32]);
			hl_s3 <= 32'(p9q_s2[63:32] * q13_s2[31:0]);
			q_s3 <= q_s2;
			p8p_s3 <= p8p_s2;
			side_s3 <= side_s2;
		end
	end

	// Stage 4: scaled correction terms.
	logic [63:0] e1raw;
	logic signed [63:0] e1_s4;
	logic signed [63:0] e2_s4;
	logic signed [63:0] q_s4;
	div_side_t side_s4;

	assign e1raw = ll_s3 + {32'(lh_s3 + hl_s3), 32'b0};

	always_ff @(posedge clk) begin
		if (adv) begin
			e1_s4 <= signed'(e1raw) >>> 25;
			e2_s4 <= p8p_s3 >>> 19;
			q_s4 <= q_s3;
			side_s4 <= side_s3;
		end
	end

	// Stage 5: final sum into the output register; a zero divisor forces zero.
	logic signed [63:0] psum;
	logic signed [63:0] pres;
	result_t res_q;

	assign psum = q_s4 + e1_s4 + e2_s4;
	assign pres = (psum >>> 8) + (64'(cal.p7) <<< 4);

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.temperature <= side_s4.temperature;
			res_q.pressure <= side_s4.zero_div ? 32'd0 : pres[31:0];
			res_q.pressure_valid <= !side_s4.zero_div;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[4:1], in_valid};
		end
	end

	assign out_valid = vld_q[5];
	assign out_item = res_q;

endmodule

/* design/pressure_temperature_compensation.sv */
`timescale 1ns / 1ps

// Barometric temperature and pressure compensation. Each item carries one raw
// temperature and one raw pressure conversion and yields one result: the
// temperature in hundredths of a degree (saturated to 20 bits), the pressure in
// pascals as unsigned Q24.8, and a flag that is low when the pressure divisor
// was zero (pressure then reads 0). The block is a fixed pipeline of 79 stages:
// ten stages of calibration arithmetic, one 64-stage unsigned divider that
// resolves one quotient bit per stage, four stages of sign restoration and
// correction terms, and the output register. An item can enter every cycle,
// so throughput is one item per cycle; all stages hold while a valid result
// is stalled. Calibration words are written through cfg_we/cfg_index/cfg_data
// (index 0: T1, T2, T3, P1; index 1: P2..P5; index 2: P6..P9; word k at bits
// 16k+15..16k) and must only be changed while no items are in flight.
module pressure_temperature_compensation import ptc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_stall,
	input sample_t sample,
	output logic result_valid,
	input logic result_stall,
	output result_t result,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [63:0] cfg_data
);

	logic [63:0] group_a_q;
	logic [63:0] group_b_q;
	logic [63:0] group_c_q;
	calib_t cal;
	logic adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_a_q <= '0;
			group_b_q <= '0;
			group_c_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GROUP_A: group_a_q <= cfg_data;
				CFG_GROUP_B: group_b_q <= cfg_data;
				CFG_GROUP_C: group_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unpack the calibration words.
	assign cal.t1 = group_a_q[15:0];
	assign cal.t2 = signed'(group_a_q[31:16]);
	assign cal.t3 = signed'(group_a_q[47:32]);
	assign cal.p1 = group_a_q[63:48];
	assign cal.p2 = signed'(group_b_q[15:0]);
	assign cal.p3 = signed'(group_b_q[31:16]);
	assign cal.p4 = signed'(group_b_q[47:32]);
	assign cal.p5 = signed'(group_b_q[63:48]);
	assign cal.p6 = signed'(group_c_q[15:0]);
	assign cal.p7 = signed'(group_c_q[31:16]);
	assign cal.p8 = signed'(group_c_q[47:32]);
	assign cal.p9 = signed'(group_c_q[63:48]);

	// The pipeline advances unless a finished result is being held.
	assign adv = !(result_valid && result_stall);
	assign sample_stall = !adv;

	logic front_valid;
	logic [63:0] front_num;
	logic [63:0] front_den;
	div_side_t front_side;
	logic div_valid;
	logic [63:0] div_quo;
	div_side_t div_side;

	ptc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.cal(cal),
		.in_valid(sample_valid),
		.in_item(sample),
		.out_valid(front_valid),
		.out_num(front_num),
		.out_den(front_den),
		.out_side(front_side)
	);

	ptc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(front_valid),
		.in_num(front_num),
		.in_den(front_den),
		.in_side(front_side),
		.out_valid(div_valid),
		.out_quo(div_quo),
		.out_side(div_side)
	);

	ptc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.cal(cal),
		.in_valid(div_valid),
		.in_quo(div_quo),
		.in_side(div_side),
		.out_valid(result_valid),
		.out_item(result)
	);

endmodule
